>>> design/spoq_pkg.sv
// shared types, sizes and codes for the stable priority ordered queue
// no dependencies
package spoq_pkg;

    localparam int DEPTH         = 16;
    localparam int HANDLE_BITS   = 8;
    localparam int PRIORITY_BITS = 16;
    localparam int CNT_BITS      = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_SORT_ADD   = 3'd0;
    localparam logic [2:0] CMD_ADD_HEAD   = 3'd1;
    localparam logic [2:0] CMD_ADD_TAIL   = 3'd2;
    localparam logic [2:0] CMD_REM_HEAD   = 3'd3;
    localparam logic [2:0] CMD_REM_TAIL   = 3'd4;
    localparam logic [2:0] CMD_REM_HANDLE = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_PRESENT   = 3'd4;

    typedef struct packed {
        logic [2:0]                      command;
        logic [HANDLE_BITS-1:0]          node_handle;
        logic signed [PRIORITY_BITS-1:0] node_priority;
    } t_cmd;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]          result_handle;
        logic signed [PRIORITY_BITS-1:0] result_priority;
        logic [2:0]                      status;
        logic [CNT_BITS-1:0]             entry_count;
    } t_result;

    typedef struct packed {
        logic                            valid;
        logic [HANDLE_BITS-1:0]          handle;
        logic signed [PRIORITY_BITS-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_cmd cmd;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

>>> design/stable_priority_ordered_queue.sv
// top level: command sequencing, status and a row of spoq_cell positions
// uses spoq_pkg and spoq_cell
//
//  port       dir  kind      meaning
//  i_cmd      in   command   beat taken when start is high and busy is low
//  o_result   out  result    beat valid for the one cycle o_done is high
//
// a command runs in two phases: the first flags the cells, the second picks
// the position through the prefix chain of the cell row and shifts; busy is
// high in the first phase only, so a new command can be taken in the second.
// synchronous reset empties the list. results cannot be stalled.
module stable_priority_ordered_queue import spoq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    logic                r_ph1;
    logic                r_ph2;
    t_cmd                r_cmd;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    t_cell_ctl           w_ctl;
    t_entry              w_entry [DEPTH];
    t_entry              w_sel   [DEPTH];
    logic [DEPTH:0]      w_pre;
    logic [DEPTH-1:0]    w_hit;
    t_entry              w_pick;
    logic                hit_any;
    logic                is_ins;
    logic [2:0]          n_status;
    logic [HANDLE_BITS-1:0]          n_handle;
    logic signed [PRIORITY_BITS-1:0] n_prio;

    assign busy     = r_ph1;
    assign w_pre[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry left_e;
            t_entry right_e;
            if (g == 0) begin : g_first
                assign left_e = '0;
            end else begin : g_mid_l
                assign left_e = w_entry[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_mid_r
                assign right_e = w_entry[g+1];
            end
            spoq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (left_e),
                .i_right (right_e),
                .i_pre   (w_pre[g]),
                .o_entry (w_entry[g]),
                .o_pre   (w_pre[g+1]),
                .o_hit   (w_hit[g]),
                .o_sel   (w_sel[g])
            );
        end
    endgenerate

    always_comb begin
        w_pick = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_pick = w_pick | w_sel[k];
        end
    end

    assign hit_any = |w_hit;
    assign is_ins  = (r_cmd.command == CMD_SORT_ADD) || (r_cmd.command == CMD_ADD_HEAD) ||
                     (r_cmd.command == CMD_ADD_TAIL);

    always_comb begin
        w_ctl     = '0;
        w_ctl.cmd = r_cmd;
        n_status  = ST_OK;
        n_handle  = '0;
        n_prio    = '0;
        n_count   = r_count;
        if (is_ins) begin
            if (hit_any) begin
                n_status = ST_PRESENT;
            end else if (r_count == CNT_BITS'(DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.ins = r_ph2;
                n_handle  = r_cmd.node_handle;
                n_prio    = r_cmd.node_priority;
                n_count   = r_count + CNT_BITS'(1);
            end
        end else if ((r_cmd.command == CMD_REM_HEAD) || (r_cmd.command == CMD_REM_TAIL)) begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                w_ctl.rem = r_ph2;
                n_handle  = w_pick.handle;
                n_prio    = w_pick.prio;
                n_count   = r_count - CNT_BITS'(1);
            end
        end else if (r_cmd.command == CMD_REM_HANDLE) begin
            if (!hit_any) begin
                n_status = ST_NOT_FOUND;
            end else begin
                w_ctl.rem = r_ph2;
                n_handle  = w_pick.handle;
                n_prio    = w_pick.prio;
                n_count   = r_count - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        if (r_ph2) begin
            o_result.result_handle   <= n_handle;
            o_result.result_priority <= n_prio;
            o_result.status          <= n_status;
            o_result.entry_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1   <= 1'b0;
            r_ph2   <= 1'b0;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            r_ph1  <= start && !busy;
            r_ph2  <= r_ph1;
            o_done <= r_ph2;
            if (r_ph2) begin
                r_count <= n_count;
            end
        end
    end

endmodule

>>> design/spoq_cell.sv
// one list position: holds an entry, flags itself for the current command
// and shifts toward its left or right neighbor; uses spoq_pkg
module spoq_cell import spoq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_left,
    input  t_entry    i_right,
    input  logic      i_pre,
    output t_entry    o_entry,
    output logic      o_pre,
    output logic      o_hit,
    output t_entry    o_sel
);

    t_entry r_entry;
    logic   r_mark;
    logic   r_hit;
    logic   n_mark;
    logic   n_hit;

    always_comb begin
        n_hit = r_entry.valid && (r_entry.handle == i_ctl.cmd.node_handle);
        unique case (i_ctl.cmd.command)
            CMD_SORT_ADD:   n_mark = !r_entry.valid ||
                                     ($signed(i_ctl.cmd.node_priority) < $signed(r_entry.prio));
            CMD_ADD_HEAD:   n_mark = 1'b1;
            CMD_ADD_TAIL:   n_mark = !r_entry.valid;
            CMD_REM_HEAD:   n_mark = 1'b1;
            CMD_REM_TAIL:   n_mark = r_entry.valid && !i_right.valid;
            CMD_REM_HANDLE: n_mark = n_hit;
            default:        n_mark = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mark <= n_mark;
        r_hit  <= n_hit;
    end

    // cells at or past the chosen position move one place
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_pre) begin
                r_entry <= i_left;
            end else if (r_mark) begin
                r_entry <= {1'b1, i_ctl.cmd.node_handle, i_ctl.cmd.node_priority};
            end
        end else if (i_ctl.rem && o_pre) begin
            r_entry <= i_right;
        end
    end

    assign o_entry = r_entry;
    assign o_pre   = i_pre | r_mark;
    assign o_hit   = r_hit;
    assign o_sel   = (r_mark && !i_pre) ? r_entry : '0;

endmodule

>>> design/spoq_chk.sv
// port-level checks for the stable priority ordered queue, bound to the top
// uses spoq_pkg
module spoq_chk import spoq_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result beat missing three cycles after command");

    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beats back to back");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.entry_count <= CNT_BITS'(DEPTH)))
        else $error("entry count above depth");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |->
        ((o_result.result_handle == '0) && (o_result.result_priority == '0)))
        else $error("failed command returned an entry");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_EMPTY)) |-> (o_result.entry_count == '0))
        else $error("empty status with entries held");

endmodule

bind stable_priority_ordered_queue spoq_chk u_spoq_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

>>> tb/tb_stable_priority_ordered_queue.sv
`timescale 1ns / 1ps
// self-checking testbench for stable_priority_ordered_queue: directed and random commands
// depends on spoq_pkg and the stable_priority_ordered_queue rtl
module tb_stable_priority_ordered_queue;
    import spoq_pkg::*;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS   = 450;
    localparam int PHASE_ITEMS    = 60;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DRAIN_CYCLES   = 8;

    class list_scoreboard;
        logic [HANDLE_BITS-1:0]          held_handle [DEPTH];
        logic signed [PRIORITY_BITS-1:0] held_prio   [DEPTH];
        int      held_count;
        t_result pending_results [$];
        int      n_commands;
        int      n_checked;
        int      n_errors;
        int      status_seen [8];

        function new();
            held_count = 0;
            n_commands = 0;
            n_checked  = 0;
            n_errors   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int find_entry(logic [HANDLE_BITS-1:0] h);
            for (int i = 0; i < held_count; i++) begin
                if (held_handle[i] == h) return i;
            end
            return -1;
        endfunction

        function void insert_entry(int pos, logic [HANDLE_BITS-1:0] h,
                                   logic signed [PRIORITY_BITS-1:0] p);
            for (int i = held_count; i > pos; i--) begin
                held_handle[i] = held_handle[i-1];
                held_prio[i]   = held_prio[i-1];
            end
            held_handle[pos] = h;
            held_prio[pos]   = p;
            held_count++;
        endfunction

        function void remove_entry(int pos, ref t_result r);
            r.result_handle   = held_handle[pos];
            r.result_priority = held_prio[pos];
            for (int i = pos; i + 1 < held_count; i++) begin
                held_handle[i] = held_handle[i+1];
                held_prio[i]   = held_prio[i+1];
            end
            held_count--;
        endfunction

        // works out the result of one accepted command beat and queues it
        function void note_command(t_cmd c);
            t_result                         r;
            int                              pos;
            int                              idx;
            logic signed [PRIORITY_BITS-1:0] p;
            r        = '0;
            r.status = ST_OK;
            p        = c.node_priority;
            case (c.command) inside
                CMD_SORT_ADD, CMD_ADD_HEAD, CMD_ADD_TAIL: begin
                    // duplicate check wins over full
                    if (find_entry(c.node_handle) >= 0) begin
                        r.status = ST_PRESENT;
                    end else if (held_count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        if (c.command == CMD_ADD_HEAD) begin
                            pos = 0;
                        end else if (c.command == CMD_ADD_TAIL) begin
                            pos = held_count;
                        end else begin
                            // after every entry of lower or equal priority
                            pos = 0;
                            while (pos < held_count && !(p < held_prio[pos])) pos++;
                        end
                        insert_entry(pos, c.node_handle, p);
                        r.result_handle   = c.node_handle;
                        r.result_priority = p;
                    end
                end
                CMD_REM_HEAD, CMD_REM_TAIL: begin
                    if (held_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        remove_entry((c.command == CMD_REM_HEAD) ? 0 : held_count - 1, r);
                    end
                end
                CMD_REM_HANDLE: begin
                    idx = find_entry(c.node_handle);
                    if (idx < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        remove_entry(idx, r);
                    end
                end
                default: begin
                end
            endcase
            r.entry_count = CNT_BITS'(held_count);
            pending_results.push_back(r);
            status_seen[r.status]++;
            n_commands++;
        endfunction

        function void compare_field(string field, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: handle %0d priority %0d status %0d",
                       got.result_handle, got.result_priority, got.status);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_handle", want.result_handle, got.result_handle);
            compare_field("result_priority", want.result_priority, got.result_priority);
            compare_field("status", want.status, got.status);
            compare_field("entry_count", want.entry_count, got.entry_count);
            n_checked++;
        endfunction
    endclass

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    list_scoreboard sb;
    bit             gaps_on = 1'b1;
    int             quiet_cycles = 0;

    stable_priority_ordered_queue u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_command(i_cmd);
            if (o_done) sb.check_result(o_result);
            if ((start && !busy) || o_done) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_cmd make_cmd(logic [2:0] op, int h, int p);
        t_cmd c;
        c.command       = op;
        c.node_handle   = h[HANDLE_BITS-1:0];
        c.node_priority = p[PRIORITY_BITS-1:0];
        return c;
    endfunction

    // holds the beat until the block takes it, with an optional gap in front
    task automatic issue(input t_cmd c);
        if (gaps_on && $urandom_range(0, 99) < 31) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_cmd random_cmd(bit fill_phase, int pool_base);
        int         roll;
        int         h;
        int         p;
        logic [2:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            op = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        end else if (roll < (fill_phase ? 70 : 30)) begin
            case ($urandom_range(0, 4))
                0:       op = CMD_ADD_HEAD;
                1:       op = CMD_ADD_TAIL;
                default: op = CMD_SORT_ADD;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       op = CMD_REM_HEAD;
                1:       op = CMD_REM_TAIL;
                default: op = CMD_REM_HANDLE;
            endcase
        end
        // a small handle pool keeps duplicates and remove hits frequent
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                        : pool_base + $urandom_range(0, 23);
        roll = $urandom_range(0, 9);
        if (roll < 6)      p = $urandom_range(0, 8) - 4;
        else if (roll < 9) p = $urandom_range(0, 65535);
        else               p = $urandom_range(0, 1) ? 32767 : -32768;
        return make_cmd(op, h, p);
    endfunction

    initial begin
        bit fill_phase;
        int pool_base;
        sb         = new();
        fill_phase = 1'b0;
        pool_base  = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list and ignored codes
        issue(make_cmd(CMD_REM_HEAD, 0, 0));
        issue(make_cmd(CMD_REM_TAIL, 255, -1));
        issue(make_cmd(CMD_REM_HANDLE, 0, 0));
        issue(make_cmd(CMD_SPARE_A, 255, 32767));
        issue(make_cmd(CMD_SPARE_B, 170, -32768));
        // extremes, equal priorities, out-of-order ends
        issue(make_cmd(CMD_SORT_ADD, 0, -32768));
        issue(make_cmd(CMD_SORT_ADD, 255, 32767));
        issue(make_cmd(CMD_SORT_ADD, 5, 0));
        issue(make_cmd(CMD_SORT_ADD, 6, 0));
        issue(make_cmd(CMD_ADD_HEAD, 7, 100));
        issue(make_cmd(CMD_ADD_TAIL, 8, -100));
        issue(make_cmd(CMD_SORT_ADD, 9, 0));
        issue(make_cmd(CMD_SORT_ADD, 5, 1));
        issue(make_cmd(CMD_REM_HANDLE, 200, 0));
        issue(make_cmd(CMD_REM_HANDLE, 6, 0));
        // fill up to depth, then a duplicate-on-full refusal
        for (int i = 0; i < 9; i++) begin
            issue(make_cmd((i % 3 == 0) ? CMD_ADD_TAIL : CMD_SORT_ADD, 20 + i, i - 4));
        end
        issue(make_cmd(CMD_SORT_ADD, 30, 0));
        issue(make_cmd(CMD_ADD_TAIL, 0, 5));
        issue(make_cmd(CMD_REM_HEAD, 0, 0));
        issue(make_cmd(CMD_REM_TAIL, 0, 0));

        // alternate filling and draining phases with random content
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % PHASE_ITEMS == 0) begin
                fill_phase = !fill_phase;
                pool_base  = $urandom_range(0, 232);
            end
            gaps_on = !(k >= 150 && k < 250);
            issue(random_cmd(fill_phase, pool_base));
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d commands, %0d results checked, %0d errors", sb.n_commands,
                 sb.n_checked, sb.n_errors);
        $display("refusals seen: %0d full, %0d duplicate, %0d empty, %0d not found",
                 sb.status_seen[ST_FULL], sb.status_seen[ST_PRESENT],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOT_FOUND]);
        if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
